[sv/assert_macros.svh]
// Assertion macros used by the checker file of the cluster chain sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside of reset.
`define FCC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("fcc check failed");

// Property checked on every clock edge, reset included.
`define FCC_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) (prop)) \
        else $error("fcc check failed during reset");

`endif

[sv/fcc_pkg.sv]
// Types, constants and codes shared by the cluster chain sequencer modules.
package fcc_pkg;

    localparam int TABLE_BYTES_DEF = 8192;

    localparam int SPC_W   = 8;
    localparam int LBA16_W = 16;
    localparam int LBA_W   = 20;
    localparam int CUR_W   = 17;
    localparam int SIC_W   = 7;
    localparam int CLU_W   = 12;
    localparam int IDX_W   = 13;
    localparam int BYTE_W  = 8;
    localparam int APB_AW  = 4;
    localparam int APB_DW  = 32;

    localparam logic [CUR_W-1:0] CHAIN_END = 17'h00FF8;
    localparam logic [SPC_W-1:0] SPC_MAX   = 8'd128;
    localparam int               ODD_SHIFT = 4;

    typedef enum logic [1:0] {
        REG_SPC        = 2'd0,
        REG_DATA_START = 2'd1,
        REG_ROOT_LBA   = 2'd2,
        REG_NONE       = 2'd3
    } t_reg;

    typedef enum logic [1:0] {
        CMD_LOAD      = 2'd0,
        CMD_OPEN_FILE = 2'd1,
        CMD_OPEN_ROOT = 2'd2,
        CMD_ADVANCE   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_LO,
        S_RD_HI,
        S_MUL,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [SPC_W-1:0]   spc;
        logic [LBA16_W-1:0] data_start;
        logic [LBA16_W-1:0] root_lba;
    } t_cfg;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [IDX_W-1:0]  waddr;
        logic [IDX_W-1:0]  raddr;
        logic [BYTE_W-1:0] wdata;
    } t_ram_req;

endpackage

[sv/fcc_regs.sv]
// APB configuration registers of the cluster chain sequencer.
module fcc_regs
    import fcc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg r_cfg;
    logic w_wr;
    t_reg w_reg;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_reg  = t_reg'(paddr[3:2]);
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.spc        <= SPC_W'(1);
            r_cfg.data_start <= '0;
            r_cfg.root_lba   <= '0;
        end else if (w_wr) begin
            case (w_reg)
                REG_SPC:        r_cfg.spc        <= pwdata[SPC_W-1:0];
                REG_DATA_START: r_cfg.data_start <= pwdata[LBA16_W-1:0];
                REG_ROOT_LBA:   r_cfg.root_lba   <= pwdata[LBA16_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_reg)
            REG_SPC:        prdata = APB_DW'(r_cfg.spc);
            REG_DATA_START: prdata = APB_DW'(r_cfg.data_start);
            REG_ROOT_LBA:   prdata = APB_DW'(r_cfg.root_lba);
            default:        prdata = '0;
        endcase
    end

endmodule

[sv/fcc_table_ram.sv]
// Allocation table memory with separate write and read addresses and a registered read.
module fcc_table_ram
    import fcc_pkg::*;
#(
    parameter int TABLE_BYTES = TABLE_BYTES_DEF
) (
    input  logic              i_clk,
    input  t_ram_req          i_req,
    output logic [BYTE_W-1:0] o_rd_data
);

    localparam int AW = $clog2(TABLE_BYTES);

    logic [BYTE_W-1:0] mem [0:TABLE_BYTES-1];
    logic [BYTE_W-1:0] r_rd_data;

    assign o_rd_data = r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr[AW-1:0]] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rd_data <= mem[i_req.raddr[AW-1:0]];
        end
    end

endmodule

[sv/fcc_seq.sv]
// Command sequencer: cluster state, chain reads and sector address arithmetic.
module fcc_seq
    import fcc_pkg::*;
#(
    parameter int TABLE_BYTES = TABLE_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        i_command,
    input  logic [IDX_W-1:0]  i_table_index,
    input  logic [BYTE_W-1:0] i_table_byte,
    input  logic [CLU_W-1:0]  i_start_cluster,
    output t_ram_req          o_ram_req,
    input  logic [BYTE_W-1:0] i_rd_data,
    output logic              o_strobe,
    output logic [LBA_W-1:0]  o_sector_lba,
    output logic              o_end_of_chain
);

    localparam logic [IDX_W:0] LIMIT = (IDX_W+1)'(TABLE_BYTES);

    t_state             r_state, n_state;
    logic [CUR_W-1:0]   r_cur, n_cur;
    logic [SIC_W-1:0]   r_sic, n_sic;
    logic               r_root, n_root;
    logic               r_load, n_load;
    logic [BYTE_W-1:0]  r_lo, n_lo;
    logic [LBA_W-1:0]   r_prod, n_prod;
    logic               r_strobe, n_strobe;
    logic [LBA_W-1:0]   r_lba, n_lba;
    logic               r_eoc, n_eoc;

    logic [SPC_W-1:0]   w_spc;
    logic [SPC_W-1:0]   w_next_sic;
    logic [IDX_W:0]     w_c3;
    logic [IDX_W-1:0]   w_idx_lo;
    logic [IDX_W-1:0]   w_idx_hi;
    logic               w_lo_ok;
    logic               w_hi_ok;
    logic               w_load_ok;
    logic [BYTE_W-1:0]  w_hi;
    logic [15:0]        w_word;
    logic [CLU_W-1:0]   w_next_clu;
    logic [LBA_W-1:0]   w_base;
    logic [LBA_W+SPC_W-1:0] w_prod_full;

    always_comb begin
        if (i_cfg.spc == '0) begin
            w_spc = SPC_W'(1);
        end else if (i_cfg.spc > SPC_MAX) begin
            w_spc = SPC_MAX;
        end else begin
            w_spc = i_cfg.spc;
        end
    end

    assign w_next_sic  = SPC_W'(r_sic) + SPC_W'(1);
    assign w_c3        = (IDX_W+1)'(r_cur[CLU_W-1:0]) + {(IDX_W+1)'(r_cur[CLU_W-1:0]) << 1};
    assign w_idx_lo    = w_c3[IDX_W:1];
    assign w_idx_hi    = w_idx_lo + IDX_W'(1);
    assign w_lo_ok     = {1'b0, w_idx_lo} < LIMIT;
    assign w_hi_ok     = {1'b0, w_idx_hi} < LIMIT;
    assign w_load_ok   = {1'b0, i_table_index} < LIMIT;
    assign w_hi        = w_hi_ok ? i_rd_data : '0;
    assign w_word      = {w_hi, r_lo};
    assign w_next_clu  = r_cur[0] ? w_word[ODD_SHIFT +: CLU_W] : w_word[CLU_W-1:0];
    assign w_base      = LBA_W'(r_cur) - LBA_W'(2);
    assign w_prod_full = (LBA_W+SPC_W)'(w_base) * (LBA_W+SPC_W)'(w_spc);

    assign busy           = (r_state != S_IDLE);
    assign o_strobe       = r_strobe;
    assign o_sector_lba   = r_lba;
    assign o_end_of_chain = r_eoc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cur    <= '0;
            r_sic    <= '0;
            r_root   <= 1'b0;
            r_load   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cur    <= n_cur;
            r_sic    <= n_sic;
            r_root   <= n_root;
            r_load   <= n_load;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo   <= n_lo;
        r_prod <= n_prod;
        r_lba  <= n_lba;
        r_eoc  <= n_eoc;
    end

    always_comb begin
        n_state   = r_state;
        n_cur     = r_cur;
        n_sic     = r_sic;
        n_root    = r_root;
        n_load    = r_load;
        n_lo      = r_lo;
        n_prod    = r_prod;
        n_strobe  = 1'b0;
        n_lba     = r_lba;
        n_eoc     = r_eoc;
        o_ram_req = '{we: 1'b0, re: 1'b0, waddr: i_table_index,
                      raddr: w_idx_lo, wdata: i_table_byte};

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_MUL;
                    n_load  = 1'b0;
                    case (t_cmd'(i_command))
                        CMD_LOAD: begin
                            n_load       = 1'b1;
                            o_ram_req.we = w_load_ok;
                        end
                        CMD_OPEN_FILE: begin
                            n_root = 1'b0;
                            n_cur  = CUR_W'(i_start_cluster);
                            n_sic  = '0;
                        end
                        CMD_OPEN_ROOT: begin
                            n_root = 1'b1;
                            n_cur  = CUR_W'(i_cfg.root_lba);
                            n_sic  = '0;
                        end
                        CMD_ADVANCE: begin
                            if (r_root) begin
                                n_cur = r_cur + CUR_W'(1);
                            end else if (r_cur < CHAIN_END) begin
                                if (w_next_sic >= w_spc) begin
                                    n_sic        = '0;
                                    o_ram_req.re = 1'b1;
                                    n_state      = S_RD_LO;
                                end else begin
                                    n_sic = w_next_sic[SIC_W-1:0];
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RD_LO: begin
                n_lo            = w_lo_ok ? i_rd_data : '0;
                o_ram_req.re    = 1'b1;
                o_ram_req.raddr = w_idx_hi;
                n_state         = S_RD_HI;
            end
            S_RD_HI: begin
                n_cur   = CUR_W'(w_next_clu);
                n_state = S_MUL;
            end
            S_MUL: begin
                n_prod  = w_prod_full[LBA_W-1:0];
                n_state = S_OUT;
            end
            S_OUT: begin
                n_strobe = 1'b1;
                n_state  = S_IDLE;
                if (r_load) begin
                    n_lba = '0;
                    n_eoc = 1'b0;
                end else if (r_root) begin
                    n_lba = LBA_W'(r_cur);
                    n_eoc = 1'b0;
                end else if (r_cur >= CHAIN_END) begin
                    n_lba = '0;
                    n_eoc = 1'b1;
                end else begin
                    n_lba = r_prod + LBA_W'(i_cfg.data_start) + LBA_W'(r_sic);
                    n_eoc = 1'b0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[sv/fat12_cluster_chain_sequencer.sv]
// Top level of the FAT12 cluster chain sequencer: registers, table memory, sequencer.
// Each command passes through the multiply and output states before its result strobe;
// an advance that crosses a cluster boundary first fetches the two table bytes of the
// chain entry in the low and high read states. Commands are accepted only while idle.
// Results cannot be stalled; each strobe lasts one cycle.
// Reset (synchronous, active low) clears the cluster state and restores the registers;
// the table is not cleared and holds unknown data until loaded.
module fat12_cluster_chain_sequencer
    import fcc_pkg::*;
#(
    parameter int TABLE_BYTES = TABLE_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        i_command,
    input  logic [IDX_W-1:0]  i_table_index,
    input  logic [BYTE_W-1:0] i_table_byte,
    input  logic [CLU_W-1:0]  i_start_cluster,
    output logic              o_strobe,
    output logic [LBA_W-1:0]  o_sector_lba,
    output logic              o_end_of_chain
);

    t_cfg              w_cfg;
    t_ram_req          w_ram_req;
    logic [BYTE_W-1:0] w_rd_data;

    fcc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    fcc_table_ram #(
        .TABLE_BYTES (TABLE_BYTES)
    ) u_ram (
        .i_clk     (i_clk),
        .i_req     (w_ram_req),
        .o_rd_data (w_rd_data)
    );

    fcc_seq #(
        .TABLE_BYTES (TABLE_BYTES)
    ) u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (w_cfg),
        .start           (start),
        .busy            (busy),
        .i_command       (i_command),
        .i_table_index   (i_table_index),
        .i_table_byte    (i_table_byte),
        .i_start_cluster (i_start_cluster),
        .o_ram_req       (w_ram_req),
        .i_rd_data       (w_rd_data),
        .o_strobe        (o_strobe),
        .o_sector_lba    (o_sector_lba),
        .o_end_of_chain  (o_end_of_chain)
    );

endmodule

[sv/fcc_checker.sv]
// Port-level assertions for the cluster chain sequencer and their bind.
`include "assert_macros.svh"

module fcc_checker
    import fcc_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic             o_strobe,
    input logic [LBA_W-1:0] o_sector_lba,
    input logic             o_end_of_chain
);

    `FCC_ASSERT(a_accept_busy, (start && !busy) |=> busy)
    `FCC_ASSERT(a_strobe_idle, o_strobe |-> !busy)
    `FCC_ASSERT(a_strobe_single, o_strobe |=> !o_strobe)
    `FCC_ASSERT(a_eoc_zero_lba, (o_strobe && o_end_of_chain) |-> (o_sector_lba == '0))
    `FCC_ASSERT_ALWAYS(a_reset_quiet, !i_rst_n |=> (!busy && !o_strobe))

endmodule

bind fat12_cluster_chain_sequencer fcc_checker u_fcc_checker (.*);

[sim/tb_top.sv]
// Self-checking testbench for the FAT12 cluster chain sequencer.
`timescale 1ns / 100ps

module tb_top;
    import fcc_pkg::*;

    typedef struct packed {
        logic [LBA_W-1:0] lba;
        logic             eoc;
    } t_sector;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              start;
    logic              busy;
    logic [1:0]        i_command;
    logic [IDX_W-1:0]  i_table_index;
    logic [BYTE_W-1:0] i_table_byte;
    logic [CLU_W-1:0]  i_start_cluster;
    logic              o_strobe;
    logic [LBA_W-1:0]  o_sector_lba;
    logic              o_end_of_chain;

    logic [BYTE_W-1:0]  fat_shadow [0:TABLE_BYTES_DEF-1];
    bit                 fat_loaded [0:TABLE_BYTES_DEF-1];
    logic [CUR_W-1:0]   cur_pos;
    logic [SIC_W-1:0]   sector_idx;
    logic               in_root;
    logic [SPC_W-1:0]   cfg_spc;
    logic [LBA16_W-1:0] cfg_data_start;
    logic [LBA16_W-1:0] cfg_root_lba;

    t_sector due_sectors [$];
    int      mismatch_count;
    int      sent_count;
    int      idle_max;

    fat12_cluster_chain_sequencer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .start           (start),
        .busy            (busy),
        .i_command       (i_command),
        .i_table_index   (i_table_index),
        .i_table_byte    (i_table_byte),
        .i_start_cluster (i_start_cluster),
        .o_strobe        (o_strobe),
        .o_sector_lba    (o_sector_lba),
        .o_end_of_chain  (o_end_of_chain)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic [SPC_W-1:0] cluster_span();
        if (cfg_spc == '0) begin
            return 8'd1;
        end
        if (cfg_spc > SPC_MAX) begin
            return SPC_MAX;
        end
        return cfg_spc;
    endfunction

    function automatic logic [CLU_W-1:0] next_cluster(logic [CLU_W-1:0] c);
        logic [IDX_W-1:0] base;
        logic [15:0]      word;
        base = IDX_W'((32'(c) * 3) / 2);
        word = {fat_shadow[base + 13'd1], fat_shadow[base]};
        return c[0] ? word[15:4] : word[11:0];
    endfunction

    function automatic bit steps_chain();
        return !in_root && cur_pos < CHAIN_END && (9'(sector_idx) + 9'd1 >= 9'(cluster_span()));
    endfunction

    function automatic t_sector predict_sector(t_cmd cmd, logic [IDX_W-1:0] idx,
                                               logic [BYTE_W-1:0] value,
                                               logic [CLU_W-1:0] clu);
        t_sector     r;
        logic [31:0] lba32;
        logic [8:0]  nxt;
        r = '0;
        case (cmd)
            CMD_LOAD: begin
                fat_shadow[idx] = value;
                fat_loaded[idx] = 1'b1;
                return r;
            end
            CMD_OPEN_FILE: begin
                in_root    = 1'b0;
                cur_pos    = CUR_W'(clu);
                sector_idx = '0;
            end
            CMD_OPEN_ROOT: begin
                in_root    = 1'b1;
                cur_pos    = CUR_W'(cfg_root_lba);
                sector_idx = '0;
            end
            default: begin
                if (in_root) begin
                    cur_pos = cur_pos + 17'd1;
                end else if (cur_pos < CHAIN_END) begin
                    nxt = 9'(sector_idx) + 9'd1;
                    if (nxt >= 9'(cluster_span())) begin
                        sector_idx = '0;
                        cur_pos    = CUR_W'(next_cluster(cur_pos[CLU_W-1:0]));
                    end else begin
                        sector_idx = nxt[SIC_W-1:0];
                    end
                end
            end
        endcase
        if (in_root) begin
            r.lba = LBA_W'(cur_pos);
        end else if (cur_pos >= CHAIN_END) begin
            r.eoc = 1'b1;
        end else begin
            lba32 = (32'(cur_pos) - 32'd2) * 32'(cluster_span()) + 32'(cfg_data_start)
                    + 32'(sector_idx);
            r.lba = lba32[LBA_W-1:0];
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : check_results
        t_sector want;
        if (i_rst_n && o_strobe) begin
            if (due_sectors.size() == 0) begin
                $error("unexpected result: sector_lba %h end_of_chain %b",
                       o_sector_lba, o_end_of_chain);
                mismatch_count++;
            end else begin
                want = due_sectors.pop_front();
                if (o_sector_lba !== want.lba) begin
                    $error("sector_lba: expected %h, got %h", want.lba, o_sector_lba);
                    mismatch_count++;
                end
                if (o_end_of_chain !== want.eoc) begin
                    $error("end_of_chain: expected %b, got %b", want.eoc, o_end_of_chain);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic send_command(t_cmd cmd, logic [IDX_W-1:0] idx, logic [BYTE_W-1:0] value,
                                logic [CLU_W-1:0] clu);
        int gap;
        gap = (idle_max > 0) ? $urandom_range(0, idle_max) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_command       <= cmd;
        i_table_index   <= idx;
        i_table_byte    <= value;
        i_start_cluster <= clu;
        start           <= 1'b1;
        do @(posedge i_clk); while (busy);
        due_sectors.push_back(predict_sector(cmd, idx, value, clu));
        sent_count++;
    endtask

    task automatic load_byte(logic [IDX_W-1:0] idx, logic [BYTE_W-1:0] value);
        send_command(CMD_LOAD, idx, value, CLU_W'($urandom));
    endtask

    task automatic open_file(logic [CLU_W-1:0] clu);
        send_command(CMD_OPEN_FILE, IDX_W'($urandom), BYTE_W'($urandom), clu);
    endtask

    task automatic open_root();
        send_command(CMD_OPEN_ROOT, IDX_W'($urandom), BYTE_W'($urandom), CLU_W'($urandom));
    endtask

    // A chain step must only read table bytes that were loaded, so missing ones are
    // filled with random values first.
    task automatic advance_sector();
        logic [IDX_W-1:0] base;
        if (steps_chain()) begin
            base = IDX_W'((32'(cur_pos) * 3) / 2);
            if (!fat_loaded[base]) begin
                load_byte(base, BYTE_W'($urandom));
            end
            if (!fat_loaded[base + 13'd1]) begin
                load_byte(base + 13'd1, BYTE_W'($urandom));
            end
        end
        send_command(CMD_ADVANCE, IDX_W'($urandom), BYTE_W'($urandom), CLU_W'($urandom));
    endtask

    task automatic set_entry(logic [CLU_W-1:0] c, logic [CLU_W-1:0] link);
        logic [IDX_W-1:0]  base;
        logic [BYTE_W-1:0] keep;
        base = IDX_W'((32'(c) * 3) / 2);
        if (c[0]) begin
            keep = fat_loaded[base] ? fat_shadow[base] : BYTE_W'($urandom);
            load_byte(base, {link[3:0], keep[3:0]});
            load_byte(base + 13'd1, link[11:4]);
        end else begin
            load_byte(base, link[7:0]);
            keep = fat_loaded[base + 13'd1] ? fat_shadow[base + 13'd1] : BYTE_W'($urandom);
            load_byte(base + 13'd1, {keep[7:4], link[11:8]});
        end
    endtask

    task automatic wait_quiet();
        @(negedge i_clk);
        start <= 1'b0;
        while (due_sectors.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_register(t_reg r, logic [APB_DW-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({r, 2'b00});
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (r)
            REG_SPC:        cfg_spc        = value[SPC_W-1:0];
            REG_DATA_START: cfg_data_start = value[LBA16_W-1:0];
            REG_ROOT_LBA:   cfg_root_lba   = value[LBA16_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_register(t_reg r, logic [APB_DW-1:0] want);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= APB_AW'({r, 2'b00});
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want) begin
            $error("prdata of register %s: expected %h, got %h", r.name(), want, prdata);
            mismatch_count++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic program_volume(logic [SPC_W-1:0] spc, logic [LBA16_W-1:0] data_start,
                                  logic [LBA16_W-1:0] root_lba);
        write_register(REG_SPC, APB_DW'(spc));
        write_register(REG_DATA_START, APB_DW'(data_start));
        write_register(REG_ROOT_LBA, APB_DW'(root_lba));
        check_register(REG_SPC, APB_DW'(spc));
        check_register(REG_DATA_START, APB_DW'(data_start));
        check_register(REG_ROOT_LBA, APB_DW'(root_lba));
    endtask

    task automatic test_register_access();
        program_volume(8'd128, 16'hFFFF, 16'h0000);
        program_volume(8'd0, 16'h0000, 16'hFFFF);
        program_volume(8'd1, 16'h0100, 16'hFFFF);
    endtask

    task automatic test_walk_before_open();
        load_byte(13'd0, 8'h03);
        load_byte(13'd1, 8'h00);
        advance_sector();
        load_byte(13'd4, 8'h80);
        load_byte(13'd5, 8'hFF);
        advance_sector();
        advance_sector();
    endtask

    task automatic test_open_extremes();
        open_file(12'h000);
        open_file(12'h001);
        open_file(12'hFF7);
        open_file(12'hFF8);
        open_file(12'hFFF);
        load_byte(13'h1FFF, 8'hFF);
        load_byte(13'h1FFE, 8'h00);
    endtask

    task automatic test_root_directory();
        open_root();
        advance_sector();
        advance_sector();
    endtask

    task automatic test_odd_even_chain();
        load_byte(13'd3, 8'hFF);
        open_file(12'h002);
        advance_sector();
        load_byte(13'd382, 8'h2F);
        load_byte(13'd383, 8'h01);
        advance_sector();
        advance_sector();
    endtask

    task automatic walk_file_chain();
        logic [CLU_W-1:0] links [6];
        logic [CLU_W-1:0] tail;
        int               len;
        int               cap;
        int               steps;
        len = $urandom_range(1, 5);
        for (int i = 0; i < len; i++) begin
            links[i] = CLU_W'($urandom_range(2, 12'hFF7));
        end
        if ($urandom_range(0, 9) == 0) begin
            links[0] = CLU_W'($urandom_range(0, 4095));
        end
        tail = ($urandom_range(0, 9) < 7) ? CLU_W'($urandom_range(12'hFF8, 12'hFFF))
                                          : CLU_W'($urandom_range(0, 4095));
        for (int i = 0; i < len; i++) begin
            set_entry(links[i], (i == len - 1) ? tail : links[i + 1]);
        end
        open_file(links[0]);
        cap = len * int'(cluster_span()) + 2;
        if (cap > 140) begin
            cap = 140;
        end
        steps = ($urandom_range(0, 3) == 0) ? $urandom_range(0, cap) : cap;
        repeat (steps) advance_sector();
    endtask

    task automatic run_volume(logic [SPC_W-1:0] spc, logic [LBA16_W-1:0] data_start,
                              logic [LBA16_W-1:0] root_lba, int idle, int budget);
        int first;
        int pick;
        wait_quiet();
        program_volume(spc, data_start, root_lba);
        idle_max = idle;
        first = sent_count;
        while (sent_count - first < budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                walk_file_chain();
            end else if (pick < 75) begin
                open_root();
                repeat ($urandom_range(0, 8)) advance_sector();
            end else if (pick < 88) begin
                load_byte(IDX_W'($urandom_range(0, 8191)), BYTE_W'($urandom_range(0, 255)));
            end else if (pick < 94) begin
                open_file(CLU_W'($urandom_range(0, 4095)));
            end else begin
                advance_sector();
            end
        end
    endtask

    task automatic test_random_walks();
        run_volume(8'd1, 16'h0000, 16'h0000, 19, 175);
        run_volume(8'd4, LBA16_W'($urandom), LBA16_W'($urandom), 19, 175);
        run_volume(8'd128, 16'hFFFF, 16'hFFFF, 19, 175);
        run_volume(8'd0, LBA16_W'($urandom), LBA16_W'($urandom), 19, 175);
        run_volume(8'd255, LBA16_W'($urandom), LBA16_W'($urandom), 19, 175);
        run_volume(8'd3, LBA16_W'($urandom), LBA16_W'($urandom), 19, 175);
        run_volume(SPC_W'($urandom_range(1, 8)), LBA16_W'($urandom), 16'h0000, 19, 175);
        run_volume(8'd2, 16'hFFFF, LBA16_W'($urandom), 19, 175);
    endtask

    initial begin
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        start           = 1'b0;
        i_command       = CMD_LOAD;
        i_table_index   = '0;
        i_table_byte    = '0;
        i_start_cluster = '0;
        cur_pos         = '0;
        sector_idx      = '0;
        in_root         = 1'b0;
        cfg_spc         = 8'd1;
        cfg_data_start  = '0;
        cfg_root_lba    = '0;
        mismatch_count  = 0;
        sent_count      = 0;
        idle_max        = 19;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_register_access();
        test_walk_before_open();
        test_open_extremes();
        test_root_directory();
        test_odd_even_chain();
        test_random_walks();

        wait_quiet();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("tb_top: errors");
        $finish;
    end

endmodule
